// ===== hw/rtl/qrs_pkg.sv =====
`default_nettype none

package qrs_pkg;

  localparam int unsigned QRS_DATA_WIDTH = 32;
  localparam int unsigned QRS_FRAC_BITS  = 16;
  localparam int unsigned EPS_BITS       = 16;
  localparam int unsigned CFG_IDX_BITS   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_METHOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPS    = 2'd1;

  // root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // case flags and signs that travel with the magnitudes
  typedef struct packed {
    logic lin;    // |a| below threshold
    logic bok;    // |b| at or above threshold
    logic dlow;   // |delta| below scaled threshold
    logic dneg;   // delta negative
    logic an;
    logic bn;
    logic cn;
  } ctl_t;

  localparam int unsigned CTL_BITS = $bits(ctl_t);

endpackage

`default_nettype wire

// ===== hw/rtl/quadratic_root_solver.sv =====
`default_nettype none

// Real roots of a*x^2 + b*x + c, coefficients and roots signed fixed point.
// Input channel: in_valid_i / in_stall_o with coef_a_i, coef_b_i, coef_c_i.
// Output channel: out_valid_o / out_stall_i with root_count_o, root_one_o,
// root_two_o and overflow_o. A transfer happens when valid is high and
// stall is low.
// Throughput: one coefficient set per cycle while the output is not stalled.
// Pipeline: three front stages (magnitudes, products, delta), DATA_WIDTH+1
// square-root stages, one operand-select stage, DATA_WIDTH+2+FRAC_BITS
// divider stages and the output register. Root bits come one per stage in
// both pipelines.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 method,
// 1 threshold); write only while the pipeline is empty.
// Reset empties the pipeline and sets method 1, threshold 1.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o rises in the same cycle.
module quadratic_root_solver #(
  parameter int unsigned DATA_WIDTH = qrs_pkg::QRS_DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = qrs_pkg::QRS_FRAC_BITS
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  signed [DATA_WIDTH-1:0]        coef_a_i,
  input  wire  signed [DATA_WIDTH-1:0]        coef_b_i,
  input  wire  signed [DATA_WIDTH-1:0]        coef_c_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic        [1:0]                   root_count_o,
  output logic signed [DATA_WIDTH-1:0]        root_one_o,
  output logic signed [DATA_WIDTH-1:0]        root_two_o,
  output logic                                overflow_o,
  input  wire                                 cfg_we_i,
  input  wire         [qrs_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire         [qrs_pkg::EPS_BITS-1:0] cfg_data_i
);
  import qrs_pkg::*;

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned R   = W + 1;
  localparam int unsigned NW  = W + 2;
  localparam int unsigned QW  = NW + FRAC_BITS;
  localparam int unsigned SQW = CTL_BITS + 3 * W;

  // configuration
  logic                method_q;
  logic [EPS_BITS-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= 1'b1;
      eps_q    <= EPS_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_METHOD: method_q <= cfg_data_i[0];
        REG_EPS:    eps_q    <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // front end
  logic           fr_valid;
  ctl_t           fr_ctl;
  logic [W-1:0]   fr_am, fr_bm, fr_cm;
  logic [2*W+1:0] fr_dm;

  qrs_front #(.W(W), .F(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_i     (coef_a_i),
    .b_i     (coef_b_i),
    .c_i     (coef_c_i),
    .eps_i   (eps_q),
    .valid_o (fr_valid),
    .ctl_o   (fr_ctl),
    .am_o    (fr_am),
    .bm_o    (fr_bm),
    .cm_o    (fr_cm),
    .dm_o    (fr_dm)
  );

  // square root
  logic           sq_valid;
  logic [R-1:0]   sq_root;
  logic [SQW-1:0] sq_side;
  ctl_t           sq_ctl;
  logic [W-1:0]   sq_am, sq_bm, sq_cm;

  qrs_sqrt #(.R(R), .SW(SQW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_dm),
    .side_i  ({fr_ctl, fr_am, fr_bm, fr_cm}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign {sq_ctl, sq_am, sq_bm, sq_cm} = sq_side;

  // divider operand select
  logic          n1s, d1s, n2s, d2s;
  logic [NW-1:0] n1m, d1m, n2m, d2m;
  logic [1:0]    cnt_d;
  logic [NW-1:0] s_x, bm_x, twoa_x, cm_x;

  always_comb begin
    s_x    = NW'(sq_root);
    bm_x   = NW'(sq_bm);
    cm_x   = NW'(sq_cm);
    twoa_x = NW'(sq_am) << 1;
    n1s = 1'b0; n1m = '0; d1s = sq_ctl.an; d1m = twoa_x;
    n2s = 1'b0; n2m = '0; d2s = sq_ctl.an; d2m = twoa_x;
    cnt_d = CNT_NONE;
    if (sq_ctl.lin) begin
      n1s = !sq_ctl.cn && (sq_cm != '0);
      n1m = cm_x;
      d1s = sq_ctl.bn;
      d1m = bm_x;
      cnt_d = sq_ctl.bok ? CNT_ONE : CNT_NONE;
    end else if (sq_ctl.dlow) begin
      n1s = !sq_ctl.bn && (sq_bm != '0);
      n1m = bm_x;
      cnt_d = CNT_ONE;
    end else if (!sq_ctl.dneg) begin
      cnt_d = CNT_TWO;
      if (!method_q) begin
        // (s - b) and -(b + s), signed-magnitude
        if (sq_ctl.bn) begin
          n1s = 1'b0; n1m = s_x + bm_x;
        end else if (s_x >= bm_x) begin
          n1s = 1'b0; n1m = s_x - bm_x;
        end else begin
          n1s = 1'b1; n1m = bm_x - s_x;
        end
        if (!sq_ctl.bn) begin
          n2s = 1'b1; n2m = bm_x + s_x;
        end else if (bm_x >= s_x) begin
          n2s = 1'b0; n2m = bm_x - s_x;
        end else begin
          n2s = 1'b1; n2m = s_x - bm_x;
        end
      end else begin
        // m = -(b + sign(b)*s); x2 = 2c / m
        n1s = !sq_ctl.bn;
        n1m = s_x + bm_x;
        n2s = sq_ctl.cn;
        n2m = cm_x << 1;
        d2s = !sq_ctl.bn;
        d2m = s_x + bm_x;
      end
    end
  end

  logic          pr_valid_q;
  logic [NW-1:0] n1m_q, d1m_q, n2m_q, d2m_q;
  logic          neg1_q, neg2_q;
  logic [1:0]    cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_valid_q <= 1'b0;
    end else if (en) begin
      pr_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1m_q  <= n1m;
      d1m_q  <= d1m;
      n2m_q  <= n2m;
      d2m_q  <= d2m;
      neg1_q <= n1s ^ d1s;
      neg2_q <= n2s ^ d2s;
      cnt_q  <= cnt_d;
    end
  end

  // dividers
  logic          dv1_valid, dv2_valid;
  logic [QW-1:0] q1, q2;
  logic          dz1, dz2;
  logic [2:0]    dv1_side;
  logic          dv2_side;

  qrs_div #(.NW(NW), .DW(NW), .FB(FRAC_BITS), .SW(3)) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pr_valid_q),
    .num_i   (n1m_q),
    .den_i   (d1m_q),
    .side_i  ({cnt_q, neg1_q}),
    .valid_o (dv1_valid),
    .quo_o   (q1),
    .dz_o    (dz1),
    .side_o  (dv1_side)
  );

  qrs_div #(.NW(NW), .DW(NW), .FB(FRAC_BITS), .SW(1)) u_div2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pr_valid_q),
    .num_i   (n2m_q),
    .den_i   (d2m_q),
    .side_i  (neg2_q),
    .valid_o (dv2_valid),
    .quo_o   (q2),
    .dz_o    (dz2),
    .side_o  (dv2_side)
  );

  // saturate to the signed range; returns {overflow, value}
  function automatic logic [W:0] sat_root(logic [QW-1:0] q, logic dz, logic neg);
    logic [QW-1:0] lim;
    logic [W-1:0]  vmin, vmax;
    lim  = QW'(1) << (W - 1);
    vmin = W'(1) << (W - 1);
    vmax = vmin - W'(1);
    if (dz) begin
      sat_root = {1'b1, neg ? vmin : vmax};
    end else if (neg) begin
      sat_root = (q > lim) ? {1'b1, vmin} : {1'b0, W'(QW'(0) - q)};
    end else begin
      sat_root = (q > lim - QW'(1)) ? {1'b1, vmax} : {1'b0, W'(q)};
    end
  endfunction

  logic [W:0]   s1, s2;
  logic [1:0]   fcnt;
  logic [W-1:0] r1_d, r2_d;
  logic         ovf_d;

  always_comb begin
    fcnt = dv1_side[2:1];
    s1   = sat_root(q1, dz1, dv1_side[0]);
    s2   = sat_root(q2, dz2, dv2_side);
    r1_d  = '0;
    r2_d  = '0;
    ovf_d = 1'b0;
    case (fcnt)
      CNT_ONE: begin
        r1_d  = s1[W-1:0];
        r2_d  = s1[W-1:0];
        ovf_d = s1[W];
      end
      CNT_TWO: begin
        r1_d  = s1[W-1:0];
        r2_d  = s2[W-1:0];
        ovf_d = s1[W] | s2[W];
      end
      default: ;
    endcase
  end

  logic [1:0]   cnt_out_q;
  logic [W-1:0] r1_q, r2_q;
  logic         ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv1_valid & dv2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cnt_out_q <= fcnt;
      r1_q      <= r1_d;
      r2_q      <= r2_d;
      ovf_q     <= ovf_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign root_count_o = cnt_out_q;
  assign root_one_o   = r1_q;
  assign root_two_o   = r2_q;
  assign overflow_o   = ovf_q;

  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_count_o == CNT_NONE) |->
      (root_one_o == '0) && (root_two_o == '0) && !overflow_o)
    else $error("no-root result carries nonzero data");

  a_count_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (root_count_o == CNT_NONE) || (root_count_o == CNT_ONE) ||
      (root_count_o == CNT_TWO))
    else $error("illegal root count");

  a_single_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_count_o == CNT_ONE) |-> root_one_o == root_two_o)
    else $error("single root differs between outputs");

  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall out of step with output stall");

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_front.sv =====
`default_nettype none

module qrs_front #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           en_i,
  input  wire                           valid_i,
  input  wire  signed [W-1:0]           a_i,
  input  wire  signed [W-1:0]           b_i,
  input  wire  signed [W-1:0]           c_i,
  input  wire         [qrs_pkg::EPS_BITS-1:0] eps_i,
  output logic                          valid_o,
  output qrs_pkg::ctl_t                 ctl_o,
  output logic        [W-1:0]           am_o,
  output logic        [W-1:0]           bm_o,
  output logic        [W-1:0]           cm_o,
  output logic        [2*W+1:0]         dm_o
);
  import qrs_pkg::*;

  localparam int unsigned DMW = 2 * W + 2;
  localparam int unsigned TW  = DMW + F + EPS_BITS;

  // stage 1: sign and magnitude
  logic         v1_q;
  logic         an1_q, bn1_q, cn1_q;
  logic [W-1:0] am1_q, bm1_q, cm1_q;
  // stage 2: products
  logic           v2_q;
  logic           an2_q, bn2_q, cn2_q, lin2_q, bok2_q;
  logic [W-1:0]   am2_q, bm2_q, cm2_q;
  logic [2*W-1:0] pp2_q, ac2_q;
  // stage 3: delta
  logic           v3_q;
  ctl_t           ctl3_q;
  logic [W-1:0]   am3_q, bm3_q, cm3_q;
  logic [DMW-1:0] dm3_q;

  logic [DMW-1:0] p_ext, q4_ext, dm_d;
  logic           dneg_d;

  always_comb begin
    p_ext  = DMW'(pp2_q);
    q4_ext = {ac2_q, 2'b00};
    dneg_d = 1'b0;
    if (an2_q ^ cn2_q) begin
      dm_d = p_ext + q4_ext;
    end else if (p_ext >= q4_ext) begin
      dm_d = p_ext - q4_ext;
    end else begin
      dm_d   = q4_ext - p_ext;
      dneg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an1_q <= a_i[W-1];
      bn1_q <= b_i[W-1];
      cn1_q <= c_i[W-1];
      am1_q <= a_i[W-1] ? W'(-a_i) : W'(a_i);
      bm1_q <= b_i[W-1] ? W'(-b_i) : W'(b_i);
      cm1_q <= c_i[W-1] ? W'(-c_i) : W'(c_i);

      an2_q  <= an1_q;
      bn2_q  <= bn1_q;
      cn2_q  <= cn1_q;
      lin2_q <= am1_q < W'(eps_i);
      bok2_q <= bm1_q >= W'(eps_i);
      am2_q  <= am1_q;
      bm2_q  <= bm1_q;
      cm2_q  <= cm1_q;
      pp2_q  <= (2*W)'(bm1_q) * (2*W)'(bm1_q);
      ac2_q  <= (2*W)'(am1_q) * (2*W)'(cm1_q);

      ctl3_q.lin   <= lin2_q;
      ctl3_q.bok   <= bok2_q;
      ctl3_q.dlow  <= TW'(dm_d) < (TW'(eps_i) << F);
      ctl3_q.dneg  <= dneg_d;
      ctl3_q.an    <= an2_q;
      ctl3_q.bn    <= bn2_q;
      ctl3_q.cn    <= cn2_q;
      am3_q <= am2_q;
      bm3_q <= bm2_q;
      cm3_q <= cm2_q;
      dm3_q <= dm_d;
    end
  end

  assign valid_o = v3_q;
  assign ctl_o   = ctl3_q;
  assign am_o    = am3_q;
  assign bm_o    = bm3_q;
  assign cm_o    = cm3_q;
  assign dm_o    = dm3_q;

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_sqrt.sv =====
`default_nettype none

// Floor square root, one root bit per stage.
module qrs_sqrt #(
  parameter int unsigned R  = 33,
  parameter int unsigned SW = 1
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             en_i,
  input  wire             valid_i,
  input  wire  [2*R-1:0]  rad_i,
  input  wire  [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [R-1:0]    root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned RADW = 2 * R;
  localparam int unsigned RMW  = R + 3;

  logic [R-1:0]    vld_q;
  logic [RADW-1:0] rad_q  [R];
  logic [RMW-1:0]  rem_q  [R];
  logic [R-1:0]    root_q [R];
  logic [SW-1:0]   side_q [R];

  logic [RADW-1:0] rad_in  [R];
  logic [RMW-1:0]  rem_in  [R];
  logic [R-1:0]    root_in [R];
  logic [SW-1:0]   side_in [R];
  logic [RMW-1:0]  rem_n   [R];
  logic [RMW-1:0]  trial   [R];
  logic [R-1:0]    ge;

  always_comb begin
    for (int k = 0; k < R; k++) begin
      if (k == 0) begin
        rad_in[k]  = rad_i;
        rem_in[k]  = '0;
        root_in[k] = '0;
        side_in[k] = side_i;
      end else begin
        rad_in[k]  = rad_q[k-1];
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
        side_in[k] = side_q[k-1];
      end
      rem_n[k] = {rem_in[k][RMW-3:0], rad_in[k][RADW-1 -: 2]};
      trial[k] = {(RMW-2)'(root_in[k]), 2'b01};
      ge[k]    = rem_n[k] >= trial[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[R-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < R; k++) begin
        rad_q[k]  <= rad_in[k] << 2;
        rem_q[k]  <= ge[k] ? rem_n[k] - trial[k] : rem_n[k];
        root_q[k] <= {root_in[k][R-2:0], ge[k]};
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[R-1];
  assign root_o  = root_q[R-1];
  assign side_o  = side_q[R-1];

endmodule

`default_nettype wire

// ===== hw/rtl/qrs_div.sv =====
`default_nettype none

// Restoring divider, (num << FB) / den, one quotient bit per stage.
module qrs_div #(
  parameter int unsigned NW = 34,
  parameter int unsigned DW = 34,
  parameter int unsigned FB = 16,
  parameter int unsigned SW = 1
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                en_i,
  input  wire                valid_i,
  input  wire  [NW-1:0]      num_i,
  input  wire  [DW-1:0]      den_i,
  input  wire  [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [NW+FB-1:0]   quo_o,
  output logic               dz_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned QW = NW + FB;

  logic [QW-1:0] vld_q;
  logic [QW-1:0] nsh_q  [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [SW-1:0] side_q [QW];

  logic [QW-1:0] nsh_in  [QW];
  logic [DW-1:0] rem_in  [QW];
  logic [DW-1:0] den_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [SW-1:0] side_in [QW];
  logic [DW:0]   x       [QW];
  logic [DW:0]   dx      [QW];
  logic [QW-1:0] ge;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        nsh_in[k]  = {num_i, {FB{1'b0}}};
        rem_in[k]  = '0;
        den_in[k]  = den_i;
        quo_in[k]  = '0;
        side_in[k] = side_i;
      end else begin
        nsh_in[k]  = nsh_q[k-1];
        rem_in[k]  = rem_q[k-1];
        den_in[k]  = den_q[k-1];
        quo_in[k]  = quo_q[k-1];
        side_in[k] = side_q[k-1];
      end
      x[k]  = {rem_in[k], nsh_in[k][QW-1]};
      dx[k] = {1'b0, den_in[k]};
      ge[k] = x[k] >= dx[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) begin
        nsh_q[k]  <= nsh_in[k] << 1;
        rem_q[k]  <= ge[k] ? DW'(x[k] - dx[k]) : DW'(x[k]);
        den_q[k]  <= den_in[k];
        quo_q[k]  <= {quo_in[k][QW-2:0], ge[k]};
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign dz_o    = den_q[QW-1] == '0;
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

// ===== dv/quadratic_root_solver_test.sv =====
`timescale 1ns / 100ps

module quadratic_root_solver_test;
  import qrs_pkg::*;

  localparam int unsigned DW = QRS_DATA_WIDTH;
  localparam int unsigned FB = QRS_FRAC_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct {
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] c;
  } coefs_t;

  typedef struct {
    logic [1:0]    cnt;
    logic [DW-1:0] r1;
    logic [DW-1:0] r2;
    bit            ovf;
  } roots_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [DW-1:0] coef_a_i, coef_b_i, coef_c_i;
  logic [1:0] root_count_o;
  logic signed [DW-1:0] root_one_o, root_two_o;
  logic overflow_o;
  logic cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [EPS_BITS-1:0] cfg_data_i;

  quadratic_root_solver uut (.*);

  coefs_t pending_sets[$];
  roots_t expected_roots[$];
  bit method_q;
  logic [EPS_BITS-1:0] eps_q;
  bit tight;
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned gap_left, wait_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // square-root floor of a wide value
  function automatic logic [63:0] sqrt_floor(input logic [127:0] n);
    logic [127:0] res, bitv;
    res = '0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  function automatic logic [DW-1:0] div_sat(input bit nneg, input logic [63:0] num,
                                            input bit dneg, input logic [63:0] den,
                                            inout bit ovf);
    bit neg;
    logic [127:0] q, lim;
    neg = nneg != dneg;
    lim = 128'd1 << (DW - 1);
    if (den == 0) begin
      ovf = 1'b1;
      return neg ? lim[DW-1:0] : lim[DW-1:0] - 1;
    end
    q = (128'(num) << FB) / 128'(den);
    if (neg) begin
      if (q > lim) begin
        ovf = 1'b1;
        return lim[DW-1:0];
      end
      return -q[DW-1:0];
    end
    if (q > lim - 1) begin
      ovf = 1'b1;
      return lim[DW-1:0] - 1;
    end
    return q[DW-1:0];
  endfunction

  function automatic void sign_mag(input logic [DW-1:0] v, output bit neg,
                                   output logic [63:0] mag);
    neg = v[DW-1];
    mag = neg ? (64'd1 << DW) - 64'(v) : 64'(v);
  endfunction

  function automatic void signed_sum(input bit sa, input logic [63:0] ma, input bit sb,
                                     input logic [63:0] mb, output bit sr,
                                     output logic [63:0] mr);
    if (sa == sb) begin
      sr = sa; mr = ma + mb;
    end else if (ma >= mb) begin
      sr = sa; mr = ma - mb;
    end else begin
      sr = sb; mr = mb - ma;
    end
  endfunction

  function automatic roots_t solve_roots(input coefs_t k);
    roots_t r;
    bit an, bn, cn, dneg, sg;
    logic [63:0] am, bm, cm, eps, s, mg;
    logic [127:0] p, q, dm, thr;
    r.cnt = CNT_NONE; r.r1 = '0; r.r2 = '0; r.ovf = 1'b0;
    sign_mag(k.a, an, am);
    sign_mag(k.b, bn, bm);
    sign_mag(k.c, cn, cm);
    eps = 64'(eps_q);
    if (am < eps) begin
      if (bm >= eps) begin
        r.r1 = div_sat(!cn && cm != 0, cm, bn, bm, r.ovf);
        r.r2 = r.r1;
        r.cnt = CNT_ONE;
      end
    end else begin
      p = 128'(bm) * 128'(bm);
      q = (128'(am) * 128'(cm)) << 2;
      thr = 128'(eps) << FB;
      dneg = 1'b0;
      if (an != cn) dm = p + q;
      else if (p >= q) dm = p - q;
      else begin
        dm = q - p;
        dneg = 1'b1;
      end
      if (dm < thr) begin
        r.r1 = div_sat(!bn && bm != 0, bm, an, am << 1, r.ovf);
        r.r2 = r.r1;
        r.cnt = CNT_ONE;
      end else if (!dneg) begin
        s = sqrt_floor(dm);
        if (!method_q) begin
          signed_sum(1'b0, s, !bn, bm, sg, mg);
          r.r1 = div_sat(sg, mg, an, am << 1, r.ovf);
          signed_sum(!bn, bm, 1'b1, s, sg, mg);
          r.r2 = div_sat(sg, mg, an, am << 1, r.ovf);
        end else begin
          // m takes the sign opposite to b so there is no cancellation
          sg = !bn;
          mg = s + bm;
          r.r1 = div_sat(sg, mg, an, am << 1, r.ovf);
          r.r2 = div_sat(cn, cm << 1, sg, mg, r.ovf);
        end
        r.cnt = CNT_TWO;
      end
    end
    return r;
  endfunction

  task automatic report(input string what);
    $display("mismatch @%0d: %s", cycles, what);
    errors++;
  endtask

  function automatic int unsigned draw_wait();
    return tight ? 0 : $urandom_range(0, 8);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    coefs_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      coef_a_i <= '0; coef_b_i <= '0; coef_c_i <= '0;
      gap_left = 0;
    end else if (in_valid_i && !in_stall_o) begin
      expected_roots.push_back(solve_roots('{coef_a_i, coef_b_i, coef_c_i}));
      gap_left = draw_wait();
      if (gap_left == 0 && pending_sets.size() > 0) begin
        nxt = pending_sets.pop_front();
        coef_a_i <= nxt.a; coef_b_i <= nxt.b; coef_c_i <= nxt.c;
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i) begin
      if (gap_left > 0) gap_left = gap_left - 1;
      else if (pending_sets.size() > 0) begin
        nxt = pending_sets.pop_front();
        coef_a_i <= nxt.a; coef_b_i <= nxt.b; coef_c_i <= nxt.c;
        in_valid_i <= 1'b1;
      end
    end
  end

  // long receiver hold-off while the first phase is streaming
  logic hold_off;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hold_off <= 1'b0;
    else hold_off <= cycles >= 150 && cycles < 550;
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    roots_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      wait_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_roots.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = expected_roots.pop_front();
          if (root_count_o !== e.cnt)
            report($sformatf("count %0d, want %0d", root_count_o, e.cnt));
          if (root_one_o !== e.r1)
            report($sformatf("root_one %h, want %h", root_one_o, e.r1));
          if (root_two_o !== e.r2)
            report($sformatf("root_two %h, want %h", root_two_o, e.r2));
          if (overflow_o !== e.ovf)
            report($sformatf("overflow %b, want %b", overflow_o, e.ovf));
        end
        wait_left = draw_wait();
      end else if (wait_left > 0) begin
        wait_left = wait_left - 1;
      end
      out_stall_i <= hold_off || wait_left > 0;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [EPS_BITS-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_METHOD) method_q = v[0];
    else if (idx == REG_EPS) eps_q = v;
  endtask

  task automatic add_set(input logic [DW-1:0] a, input logic [DW-1:0] b,
                         input logic [DW-1:0] c);
    pending_sets.push_back('{a, b, c});
  endtask

  function automatic logic [DW-1:0] rand_coef();
    logic [DW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = $urandom_range(0, 3);
      2: v = 32'h8000_0000 + $urandom_range(0, 1) * 32'h7fff_ffff;
      3: v = 32'd1 << $urandom_range(0, 30);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic add_directed();
    add_set(0, 0, 32'h0001_0000);                       // no root at all
    add_set(0, 32'h0002_0000, 32'hfffc_0000);           // linear
    add_set(0, 32'h8000_0000, 32'h7fff_ffff);
    add_set(32'h0001_0000, 32'h0002_0000, 32'h0001_0000); // double root
    add_set(32'h0001_0000, 0, 32'h0001_0000);           // negative delta
    add_set(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000); // roots 1, 2
    add_set(32'hffff_0000, 32'h0001_0000, 32'h0006_0000);
    add_set(32'd1, 32'h0001_0000, 32'h7fff_ffff);       // negative delta
    add_set(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_set(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_set(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    add_set(0, 0, 0);
  endtask

  task automatic add_random(input int n);
    int r1, r2, k;
    longint a, b, c;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // integer roots, sometimes coinciding
          r1 = $signed($urandom_range(0, 400)) - 200;
          r2 = $urandom_range(0, 3) == 0 ? r1 : $signed($urandom_range(0, 400)) - 200;
          k = $signed($urandom_range(1, 16)) * ($urandom_range(0, 1) ? 1 : -1);
          a = longint'(k) <<< $urandom_range(4, 16);
          b = -a * (r1 + r2);
          c = a * r1 * r2;
          add_set(a[31:0], b[31:0], c[31:0]);
        end
        4, 5: add_set($urandom_range(0, 2), rand_coef(), rand_coef());
        default: add_set(rand_coef(), rand_coef(), rand_coef());
      endcase
    end
  endtask

  task automatic drain();
    while (pending_sets.size() > 0 || in_valid_i || expected_roots.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    tight = 1'b0;
    method_q = 1'b1;
    eps_q = 1;
    cfg_we_i = 1'b0; cfg_idx_i = REG_METHOD; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    add_directed();
    add_random(90);
    drain();
    for (int ph = 1; ph < 8; ph++) begin
      write_reg(REG_METHOD, ph[0]);
      case (ph)
        1, 2: write_reg(REG_EPS, 0);
        3, 4: write_reg(REG_EPS, 16'hffff);
        5: write_reg(REG_SPARE, 16'h5a5a);
        default: write_reg(REG_EPS, $urandom_range(0, 300));
      endcase
      tight = ph == 4 || ph == 6;
      if (ph == 2) add_directed();
      add_random(85);
      drain();
    end
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
